/* rtl/plom_pkg.sv */
// ----------------------------------------------------------------------------
// plom_pkg
// Shared widths and default sizes of the price level order matcher.
// ----------------------------------------------------------------------------
package plom_pkg;

  localparam int unsigned PRICE_W = 10;  // price field width on the ports
  localparam int unsigned QTY_W   = 32;  // order quantity width

  localparam int unsigned PRICE_LEVELS_DEF = 1024;
  localparam int unsigned LEVEL_WIDTH_DEF  = 48;

endpackage

/* rtl/plom_order_if.sv */
// ----------------------------------------------------------------------------
// plom_order_if
// Order channel: valid/ready handshake with side, quantity and price level.
// ----------------------------------------------------------------------------
interface plom_order_if;

  logic                         valid;
  logic                         ready;
  logic                         side;
  logic [plom_pkg::QTY_W-1:0]   quantity;
  logic [plom_pkg::PRICE_W-1:0] price_level;

  modport source (output valid, output side, output quantity, output price_level,
                  input ready);
  modport sink   (input valid, input side, input quantity, input price_level,
                  output ready);

endinterface

/* rtl/plom_result_if.sv */
// ----------------------------------------------------------------------------
// plom_result_if
// Result channel: valid/ready handshake with best ask, best bid, last trade.
// ----------------------------------------------------------------------------
interface plom_result_if;

  logic                         valid;
  logic                         ready;
  logic                         ask_valid;
  logic [plom_pkg::PRICE_W-1:0] best_ask_price;
  logic                         bid_valid;
  logic [plom_pkg::PRICE_W-1:0] best_bid_price;
  logic                         trade_seen;
  logic [plom_pkg::PRICE_W-1:0] last_trade_price;

  modport source (output valid, output ask_valid, output best_ask_price,
                  output bid_valid, output best_bid_price, output trade_seen,
                  output last_trade_price, input ready);
  modport sink   (input valid, input ask_valid, input best_ask_price,
                  input bid_valid, input best_bid_price, input trade_seen,
                  input last_trade_price, output ready);

endinterface

/* rtl/plom_ram.sv */
// ----------------------------------------------------------------------------
// plom_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module plom_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/price_level_order_matcher.sv */
// ----------------------------------------------------------------------------
// price_level_order_matcher
// Aggregated limit order book: open quantity per price for each side, kept in
// two level memories, matched best bid against best ask after every in-range order.
// ----------------------------------------------------------------------------
//
//   channel   dir   words
//   order_i   in    side, quantity, price_level
//   result_o  out   ask_valid, best_ask_price, bid_valid, best_bid_price,
//                   trade_seen, last_trade_price
//
// After reset a clearing pass zeroes both level memories. An order with a price
// outside 1..PRICE_LEVELS-1 goes straight to the result; any other is added to
// its level, then walked and matched: a walk step moves either pointer or both,
// a match writes both memories, and each step, match and the final check read
// both memories, then evaluate. A new order is taken while a result waits; the
// sequencer stalls only when the previous result is still not taken.
// ----------------------------------------------------------------------------
module price_level_order_matcher #(
  parameter int unsigned PRICE_LEVELS = plom_pkg::PRICE_LEVELS_DEF,
  parameter int unsigned LEVEL_WIDTH  = plom_pkg::LEVEL_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  plom_order_if.sink    order_i,
  plom_result_if.source result_o
);

  localparam int unsigned AW  = $clog2(PRICE_LEVELS);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned LW  = LEVEL_WIDTH;
  localparam int unsigned SW  = ((LW > plom_pkg::QTY_W) ? LW : plom_pkg::QTY_W) + 1;
  localparam int unsigned XW  = PW + plom_pkg::PRICE_W;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_ADD     = 3'd2;
  localparam logic [2:0] ST_STEP_RD = 3'd3;
  localparam logic [2:0] ST_STEP_EV = 3'd4;
  localparam logic [2:0] ST_RESP    = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] bid_q, bid_d;
  logic [PW-1:0] ask_q, ask_d;
  logic [AW-1:0] last_q, last_d;
  logic          traded_q, traded_d;
  logic          out_valid_q, out_valid_d;

  logic                           side_q;
  logic [plom_pkg::QTY_W-1:0]     qty_q;
  logic [AW-1:0]                  addr_q;

  logic                           ask_valid_q;
  logic [plom_pkg::PRICE_W-1:0]   ask_px_q;
  logic                           bid_valid_q;
  logic [plom_pkg::PRICE_W-1:0]   bid_px_q;
  logic                           seen_q;
  logic [plom_pkg::PRICE_W-1:0]   last_px_q;

  // level memory ports
  logic          buy_we,    sell_we;
  logic [AW-1:0] buy_waddr, sell_waddr;
  logic [LW-1:0] buy_wdata, sell_wdata;
  logic [AW-1:0] buy_raddr, sell_raddr;
  logic [LW-1:0] buy_rdata, sell_rdata;

  // input decode
  logic [XW-1:0] in_ext;
  logic          in_ok;
  logic [AW-1:0] in_addr;
  logic          accept;

  // add path
  logic [LW-1:0] add_base;
  logic [SW-1:0] add_sum;
  logic [SW-1:0] level_max_ext;
  logic [LW-1:0] add_sat;

  // match path
  logic          bid_live, ask_live;
  logic          bid_empty, ask_empty;
  logic          do_match;
  logic [LW-1:0] match_amt;

  // result
  logic          load_out;
  logic [XW-1:0] ask_ext, bid_ext, last_ext;

  assign in_ext  = {{PW{1'b0}}, order_i.price_level};
  assign in_ok   = (order_i.price_level != '0) && (in_ext < XW'(PRICE_LEVELS));
  assign in_addr = in_ext[AW-1:0];

  assign order_i.ready = (state_q == ST_IDLE);
  assign accept        = order_i.valid && order_i.ready;

  assign add_base      = side_q ? sell_rdata : buy_rdata;
  assign add_sum       = {{(SW-LW){1'b0}}, add_base} + {{(SW-plom_pkg::QTY_W){1'b0}}, qty_q};
  assign level_max_ext = {{(SW-LW){1'b0}}, {LW{1'b1}}};
  assign add_sat       = (add_sum > level_max_ext) ? {LW{1'b1}} : add_sum[LW-1:0];

  assign bid_live  = (bid_q != '0);
  assign ask_live  = (ask_q < PW'(PRICE_LEVELS));
  assign bid_empty = bid_live && (buy_rdata == '0);
  assign ask_empty = ask_live && (sell_rdata == '0);
  assign do_match  = bid_live && ask_live && !bid_empty && !ask_empty &&
                     ({1'b0, bid_q} >= ask_q);
  assign match_amt = (buy_rdata < sell_rdata) ? buy_rdata : sell_rdata;

  assign load_out = (state_q == ST_RESP) && (!out_valid_q || result_o.ready);

  assign ask_ext  = {{plom_pkg::PRICE_W{1'b0}}, ask_q};
  assign bid_ext  = {{(plom_pkg::PRICE_W+1){1'b0}}, bid_q};
  assign last_ext = {{(plom_pkg::PRICE_W+1){1'b0}}, last_q};

  // read addresses: the incoming price while idle, the book pointers otherwise
  assign buy_raddr  = (state_q == ST_IDLE) ? in_addr : bid_q;
  assign sell_raddr = (state_q == ST_IDLE) ? in_addr : ask_q[AW-1:0];

  always_comb begin
    buy_we     = 1'b0;
    sell_we    = 1'b0;
    buy_waddr  = bid_q;
    sell_waddr = ask_q[AW-1:0];
    buy_wdata  = buy_rdata - match_amt;
    sell_wdata = sell_rdata - match_amt;
    case (state_q)
      ST_CLEAR: begin
        buy_we     = 1'b1;
        sell_we    = 1'b1;
        buy_waddr  = clr_q;
        sell_waddr = clr_q;
        buy_wdata  = '0;
        sell_wdata = '0;
      end
      ST_ADD: begin
        buy_we     = !side_q;
        sell_we    = side_q;
        buy_waddr  = addr_q;
        sell_waddr = addr_q;
        buy_wdata  = add_sat;
        sell_wdata = add_sat;
      end
      ST_STEP_EV: begin
        buy_we  = do_match;
        sell_we = do_match;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    bid_d       = bid_q;
    ask_d       = ask_q;
    last_d      = last_q;
    traded_d    = traded_q;
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(PRICE_LEVELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = in_ok ? ST_ADD : ST_RESP;
        end
      end
      ST_ADD: begin
        if (side_q) begin
          if ({1'b0, addr_q} < ask_q) begin
            ask_d = {1'b0, addr_q};
          end
        end else if (addr_q > bid_q) begin
          bid_d = addr_q;
        end
        state_d = ST_STEP_RD;
      end
      ST_STEP_RD: begin
        state_d = ST_STEP_EV;
      end
      ST_STEP_EV: begin
        // walk past empty levels first, then match the settled pair
        if (bid_empty || ask_empty) begin
          if (bid_empty) begin
            bid_d = bid_q - 1'b1;
          end
          if (ask_empty) begin
            ask_d = ask_q + 1'b1;
          end
          state_d = ST_STEP_RD;
        end else if (do_match) begin
          last_d   = ask_q[AW-1:0];
          traded_d = 1'b1;
          state_d  = ST_STEP_RD;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      bid_q       <= '0;
      ask_q       <= PW'(PRICE_LEVELS);
      last_q      <= '0;
      traded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      bid_q       <= bid_d;
      ask_q       <= ask_d;
      last_q      <= last_d;
      traded_q    <= traded_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the order and the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      side_q <= order_i.side;
      qty_q  <= order_i.quantity;
      addr_q <= in_addr;
    end
    if (load_out) begin
      ask_valid_q <= ask_live;
      ask_px_q    <= ask_live ? ask_ext[plom_pkg::PRICE_W-1:0] : '0;
      bid_valid_q <= bid_live;
      bid_px_q    <= bid_live ? bid_ext[plom_pkg::PRICE_W-1:0] : '0;
      seen_q      <= traded_q;
      last_px_q   <= traded_q ? last_ext[plom_pkg::PRICE_W-1:0] : '0;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.ask_valid        = ask_valid_q;
  assign result_o.best_ask_price   = ask_px_q;
  assign result_o.bid_valid        = bid_valid_q;
  assign result_o.best_bid_price   = bid_px_q;
  assign result_o.trade_seen       = seen_q;
  assign result_o.last_trade_price = last_px_q;

  plom_ram #(
    .WIDTH (LW),
    .DEPTH (PRICE_LEVELS)
  ) u_buy_ram (
    .clk_i   (clk_i),
    .we_i    (buy_we),
    .waddr_i (buy_waddr),
    .wdata_i (buy_wdata),
    .raddr_i (buy_raddr),
    .rdata_o (buy_rdata)
  );

  plom_ram #(
    .WIDTH (LW),
    .DEPTH (PRICE_LEVELS)
  ) u_sell_ram (
    .clk_i   (clk_i),
    .we_i    (sell_we),
    .waddr_i (sell_waddr),
    .wdata_i (sell_wdata),
    .raddr_i (sell_raddr),
    .rdata_o (sell_rdata)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the price level order matcher. Orders go in through
// the order channel with random gaps and the book view words come back with
// random stalls. A bench-side book computes the expected view after every
// accepted order. The stimulus runs in three phases:
//   - a short directed table,
//   - a flood of large buys on the top price level followed by an exact drain,
//   - banded random traffic with some noise.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LEVELS        = plom_pkg::PRICE_LEVELS_DEF;
  localparam int unsigned LVL_W         = plom_pkg::LEVEL_WIDTH_DEF;
  localparam int unsigned DIRECTED_ROWS = 20;
  localparam int unsigned RANDOM_ORDERS = 1800;
  localparam int unsigned FLOOD_BUYS    = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 4200;  // two full pointer walks plus slack
  localparam int unsigned LIMIT_NS      = 400_000_000;

  typedef logic [plom_pkg::PRICE_W-1:0] price_t;
  typedef logic [plom_pkg::QTY_W-1:0]   qty_t;
  typedef logic [LVL_W-1:0]             level_t;
  typedef enum logic {BUY = 1'b0, SELL = 1'b1} side_e;

  typedef struct packed {
    side_e  side;
    qty_t   quantity;
    price_t price;
  } order_t;

  typedef struct packed {
    logic   ask_valid;
    price_t best_ask;
    logic   bid_valid;
    price_t best_bid;
    logic   trade_seen;
    price_t last_trade;
  } book_view_t;

  typedef struct packed {
    order_t     ord;
    logic       fixed;
    book_view_t view;
  } plan_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  plom_order_if  order_if ();
  plom_result_if result_if ();

  price_level_order_matcher dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .order_i  (order_if),
    .result_o (result_if)
  );

  always #2 clk_i = ~clk_i;

  // Bench-side book
  level_t      bid_book [LEVELS];
  level_t      ask_book [LEVELS];
  int unsigned top_bid;
  int unsigned low_ask;
  price_t      trade_px;
  logic        traded;

  book_view_t  views_due [$];
  int unsigned mismatches = 0;
  int unsigned views_seen = 0;
  bit          flood = 1'b0;

  function automatic void settle_pointers();
    while (top_bid > 0 && bid_book[top_bid] == '0) top_bid--;
    while (low_ask < LEVELS && ask_book[low_ask] == '0) low_ask++;
  endfunction

  function automatic book_view_t match_order(order_t o);
    logic [LVL_W:0] sum;
    level_t         fill;
    book_view_t     v;
    if (o.price != '0 && o.price < LEVELS) begin
      if (o.side == SELL) begin
        sum = {1'b0, ask_book[o.price]} + o.quantity;
        ask_book[o.price] = sum[LVL_W] ? '1 : sum[LVL_W-1:0];
        if (o.price < low_ask) low_ask = 32'(o.price);
      end else begin
        sum = {1'b0, bid_book[o.price]} + o.quantity;
        bid_book[o.price] = sum[LVL_W] ? '1 : sum[LVL_W-1:0];
        if (o.price > top_bid) top_bid = 32'(o.price);
      end
    end
    settle_pointers();
    // cross while the best bid reaches the best ask; trade at the ask
    while (top_bid > 0 && low_ask < LEVELS && top_bid >= low_ask) begin
      fill = (bid_book[top_bid] < ask_book[low_ask]) ? bid_book[top_bid]
                                                      : ask_book[low_ask];
      bid_book[top_bid] = bid_book[top_bid] - fill;
      ask_book[low_ask] = ask_book[low_ask] - fill;
      trade_px = price_t'(low_ask);
      traded   = 1'b1;
      settle_pointers();
    end
    v.ask_valid  = (low_ask < LEVELS);
    v.best_ask   = v.ask_valid ? price_t'(low_ask) : '0;
    v.bid_valid  = (top_bid > 0);
    v.best_bid   = v.bid_valid ? price_t'(top_bid) : '0;
    v.trade_seen = traded;
    v.last_trade = traded ? trade_px : '0;
    return v;
  endfunction

  function automatic plan_t entry(side_e s, qty_t q, price_t p, logic fixed,
                                  book_view_t v);
    plan_t r;
    r.ord.side     = s;
    r.ord.quantity = q;
    r.ord.price    = p;
    r.fixed        = fixed;
    r.view         = v;
    return r;
  endfunction

  function automatic void field_check(string name, price_t want, price_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_order(input order_t o, input logic fixed,
                            input book_view_t typed, input bit calm);
    int unsigned gap;
    book_view_t  predicted;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      order_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    order_if.valid       <= 1'b1;
    order_if.side        <= o.side;
    order_if.quantity    <= o.quantity;
    order_if.price_level <= o.price;
    do @(posedge clk_i); while (!order_if.ready);
    predicted = match_order(o);
    views_due.push_back(fixed ? typed : predicted);
    @(negedge clk_i);
  endtask

  // Result side: random stalls, calm stretches, and one long hold during the random traffic
  initial begin : result_taker
    int unsigned stall;
    book_view_t  got;
    book_view_t  want;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = (flood || (views_seen / 60) % 3 == 2) ? 0 : $urandom_range(0, 12);
      if (views_seen % 50000 == 200) stall = HOLD_CYCLES;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
      got = {result_if.ask_valid, result_if.best_ask_price, result_if.bid_valid,
             result_if.best_bid_price, result_if.trade_seen,
             result_if.last_trade_price};
      if (views_due.size() == 0) begin
        $error("result word with no order pending");
        mismatches++;
      end else begin
        want = views_due.pop_front();
        field_check("ask_valid", price_t'(want.ask_valid), price_t'(got.ask_valid));
        field_check("best_ask_price", want.best_ask, got.best_ask);
        field_check("bid_valid", price_t'(want.bid_valid), price_t'(got.bid_valid));
        field_check("best_bid_price", want.best_bid, got.best_bid);
        field_check("trade_seen", price_t'(want.trade_seen), price_t'(got.trade_seen));
        field_check("last_trade_price", want.last_trade, got.last_trade);
      end
      views_seen++;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    plan_t       plan [DIRECTED_ROWS];
    order_t      o;
    int unsigned mid;
    int unsigned counted;
    int          px;

    foreach (bid_book[i]) begin
      bid_book[i] = '0;
      ask_book[i] = '0;
    end
    top_bid  = 0;
    low_ask  = LEVELS;
    trade_px = '0;
    traded   = 1'b0;

    order_if.valid       = 1'b0;
    order_if.side        = 1'b0;
    order_if.quantity    = '0;
    order_if.price_level = '0;

    // ignored prices and a zero quantity leave the empty book as it was
    plan[0]  = entry(BUY,  32'd1, 10'd0, 1'b1, '0);
    plan[1]  = entry(SELL, 32'd1, 10'd0, 1'b1, '0);
    plan[2]  = entry(BUY,  32'd0, 10'd5, 1'b1, '0);
    plan[3]  = entry(BUY,  32'd100, 10'd1, 1'b1,
                     {1'b0, 10'd0, 1'b1, 10'd1, 1'b0, 10'd0});
    plan[4]  = entry(SELL, 32'hFFFF_FFFF, 10'd1023, 1'b1,
                     {1'b1, 10'd1023, 1'b1, 10'd1, 1'b0, 10'd0});
    plan[5]  = entry(SELL, 32'd40, 10'd1, 1'b1,
                     {1'b1, 10'd1023, 1'b1, 10'd1, 1'b1, 10'd1});
    plan[6]  = entry(SELL, 32'd60, 10'd1, 1'b1,
                     {1'b1, 10'd1023, 1'b0, 10'd0, 1'b1, 10'd1});
    plan[7]  = entry(BUY,  32'hFFFF_FFFF, 10'd1023, 1'b1,
                     {1'b0, 10'd0, 1'b0, 10'd0, 1'b1, 10'd1023});
    plan[8]  = entry(BUY,  32'd500, 10'd1023, 1'b1,
                     {1'b0, 10'd0, 1'b1, 10'd1023, 1'b1, 10'd1023});
    plan[9]  = entry(SELL, 32'd200, 10'd1023, 1'b1,
                     {1'b0, 10'd0, 1'b1, 10'd1023, 1'b1, 10'd1023});
    plan[10] = entry(SELL, 32'd300, 10'd1022, 1'b1,
                     {1'b0, 10'd0, 1'b0, 10'd0, 1'b1, 10'd1022});
    // small book, then sweeps across several levels
    plan[11] = entry(BUY,  32'd10, 10'd500, 1'b0, '0);
    plan[12] = entry(BUY,  32'd20, 10'd498, 1'b0, '0);
    plan[13] = entry(SELL, 32'd7, 10'd505, 1'b0, '0);
    plan[14] = entry(SELL, 32'd9, 10'd503, 1'b0, '0);
    plan[15] = entry(SELL, 32'd25, 10'd497, 1'b0, '0);
    plan[16] = entry(BUY,  32'h8000_0000, 10'd510, 1'b0, '0);
    plan[17] = entry(SELL, 32'd5, 10'd0, 1'b0, '0);
    plan[18] = entry(SELL, 32'd0, 10'd300, 1'b0, '0);
    plan[19] = entry(SELL, 32'hFFFF_FFFF, 10'd498, 1'b0, '0);

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_order(plan[i].ord, plan[i].fixed, plan[i].view, 1'b0);

    // Stack up the top buy level with full-size orders, then drain it exactly
    // with sells at the same price.
    flood = 1'b1;
    o.side     = BUY;
    o.quantity = '1;
    o.price    = price_t'(LEVELS - 1);
    repeat (FLOOD_BUYS) send_order(o, 1'b0, '0, 1'b1);
    o.side = SELL;
    while (bid_book[LEVELS-1] >= level_t'(32'hFFFF_FFFF))
      send_order(o, 1'b0, '0, 1'b1);
    if (bid_book[LEVELS-1] != '0) begin
      o.quantity = qty_t'(bid_book[LEVELS-1]);
      send_order(o, 1'b0, '0, 1'b1);
    end
    flood = 1'b0;

    // Banded traffic around a drifting mid price so that books cross often
    mid     = $urandom_range(100, 900);
    counted = 0;
    while (counted < RANDOM_ORDERS) begin
      o.side = side_e'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        mid = mid + $urandom_range(0, 30) - 15;
        if (mid < 16) mid = 16;
        if (mid > 1007) mid = 1007;
      end
      if ($urandom_range(0, 99) < 4) begin
        case ($urandom_range(0, 3))
          0:       o.price = '0;
          1:       o.price = 10'd1;
          2:       o.price = 10'd1023;
          default: o.price = price_t'($urandom_range(1, 1023));
        endcase
      end else begin
        px = int'(mid) + int'($urandom_range(0, 10)) - ((o.side == SELL) ? 3 : 7);
        o.price = price_t'(px);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: o.quantity = $urandom_range(1, 1000);
        11, 12, 13, 14, 15, 16:            o.quantity = $urandom;
        17, 18: o.quantity = 32'hFFFF_FFFF - $urandom_range(0, 255);
        default:                           o.quantity = $urandom_range(1, 16);
      endcase
      if (o.quantity == '0) o.quantity = 32'd1;
      send_order(o, 1'b0, '0, (counted / 80) % 4 == 3);
      if (o.price != '0) counted++;
    end
    order_if.valid <= 1'b0;

    while (views_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
rtl/plom_pkg.sv
rtl/plom_order_if.sv
rtl/plom_result_if.sv
rtl/plom_ram.sv
rtl/price_level_order_matcher.sv
verif/tb_top.sv
